>>> rtl/vpa_pkg.sv
// Shared types and codes of the partition allocator.
// No dependencies.
package vpa_pkg;

   localparam int unsigned JOB_BITS = 8;
   localparam int unsigned LEN_BITS = 16;
   localparam int unsigned STATUS_BITS = 3;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK       = 3'd0,
      ST_NO_FIT   = 3'd1,
      ST_PRESENT  = 3'd2,
      ST_NOT_FND  = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef enum logic {
      CMD_ALLOC   = 1'b0,
      CMD_RELEASE = 1'b1
   } cmd_type;

   localparam logic CSR_FIT_POLICY  = 1'b0;
   localparam logic CSR_MEMORY_SIZE = 1'b1;

   typedef struct packed {
      logic                   cmd;
      logic [JOB_BITS-1:0]    job_id;
      logic [LEN_BITS-1:0]    req_length;
   } req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [LEN_BITS-1:0]    region_start;
      logic [LEN_BITS-1:0]    region_length;
   } rsp_type;

endpackage

>>> rtl/vpa_if.sv
// Valid/ready channel interface carrying a packed payload.
// Depends on vpa_pkg types through its type parameter.
interface vpa_if #(parameter type PAYLOAD_TYPE = logic) (input logic clock);
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/variable_partition_allocator_unit.sv
// Variable-partition allocator: top level with both tables in memories.
// Depends on vpa_pkg and vpa_if.
//
// Use: allocate (cmd 0) or release (cmd 1) transfers arrive on req; one
// result transfer per request leaves on rsp (status, region start, length).
// Configuration: csr_we/csr_index/csr_wdata, written only while idle;
// writing memory_size resets the tables to one free region at zero (none if zero).
// The free table (MAX_JOBS+1 entries) and used table (MAX_JOBS entries) are
// synchronous memories with registered read data. A request is walked by a
// sequencer that reads each entry in a read state and checks it in a check
// state: job search over the used table, fit or neighbor search over the free
// table, then shift-style removal and ordered insertion, each entry moved by
// a read state and a write state. One request is processed at a time.
// The result sits in an output register; req is taken again as soon as
// the result is delivered, so a stalled receiver holds the block.
// Reset (synchronous, active high) restores fit_policy 0, memory_size 1024
// and one free region; the counts live in flip-flops, so no clearing pass.
module variable_partition_allocator_unit
   import vpa_pkg::*;
#(
   parameter int unsigned MAX_JOBS  = 16,
   parameter int unsigned ADDR_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   vpa_if.sink         req,
   vpa_if.source       rsp,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   localparam int unsigned FDEPTH = MAX_JOBS + 1;
   localparam int unsigned FA = $clog2(FDEPTH);
   localparam int unsigned UA = $clog2(MAX_JOBS);
   localparam int unsigned CW = $clog2(FDEPTH + 1);
   localparam int unsigned AB = ADDR_BITS + 1; // room for start+length

   typedef logic [AB-1:0] addr_type;

   typedef enum logic [4:0] {
      S_IDLE, S_UJOB_RD, S_UJOB_CHK, S_FSRCH_RD, S_FSRCH_CHK,
      S_REL_CHK, S_FREM_RD, S_FREM_WR, S_UINS_RD, S_UINS_CHK,
      S_USHIFT_RD, S_USHIFT_WR, S_UREM_RD, S_UREM_WR,
      S_FINS_RD, S_FINS_CHK, S_FSHIFT_RD, S_FSHIFT_WR, S_FINS_PUT,
      S_UINS_PUT, S_DONE
   } state_type;

   // memories
   addr_type            fs_mem [FDEPTH];
   addr_type            fl_mem [FDEPTH];
   addr_type            us_mem [MAX_JOBS];
   addr_type            ul_mem [MAX_JOBS];
   logic [JOB_BITS-1:0] uj_mem [MAX_JOBS];

   logic [FA-1:0] f_ra, f_wa;
   logic          f_we;
   addr_type      f_ws, f_wl, f_rs, f_rl;
   logic [UA-1:0] u_ra, u_wa;
   logic          u_we;
   addr_type      u_ws, u_wl, u_rs, u_rl;
   logic [JOB_BITS-1:0] u_wj, u_rj;

   always_ff @(posedge clock) begin
      if (f_we) begin
         fs_mem[f_wa] <= f_ws;
         fl_mem[f_wa] <= f_wl;
      end
      f_rs <= fs_mem[f_ra];
      f_rl <= fl_mem[f_ra];
      if (u_we) begin
         us_mem[u_wa] <= u_ws;
         ul_mem[u_wa] <= u_wl;
         uj_mem[u_wa] <= u_wj;
      end
      u_rs <= us_mem[u_ra];
      u_rl <= ul_mem[u_ra];
      u_rj <= uj_mem[u_ra];
   end

   // control and work registers
   state_type     state_ff, state_in;
   logic          policy_ff, policy_in;
   logic [CW-1:0] fcnt_ff, fcnt_in;
   logic [CW-1:0] ucnt_ff, ucnt_in;
   logic [CW-1:0] i_ff, i_in;          // scan index
   logic [CW-1:0] pos_ff, pos_in;
   logic [CW-1:0] n1_ff, n1_in, n2_ff, n2_in;
   logic          h1_ff, h1_in, h2_ff, h2_in;
   logic [CW-1:0] rm2_ff, rm2_in;      // second free removal
   logic          rm2v_ff, rm2v_in;
   logic [CW-1:0] k_ff, k_in;
   logic          cmd_ff, cmd_in;
   logic [JOB_BITS-1:0] job_ff, job_in;
   addr_type      len_ff, len_in;      // request length
   addr_type      s_ff, s_in, l_ff, l_in;   // source region
   addr_type      ms_ff, ms_in, ml_ff, ml_in;
   logic          fins_ff, fins_in;    // free insertion pending
   logic          mv_ff, mv_in;        // neighbor gather mode
   logic          rsp_v_ff, rsp_v_in;
   rsp_type       rsp_ff, rsp_in;
   logic [ADDR_BITS-1:0] msize;

   assign req.ready   = (state_ff == S_IDLE) && !rsp_v_ff;
   assign rsp.valid   = rsp_v_ff;
   assign rsp.payload = rsp_ff;

   // clear pass is not needed: writing memory size writes entry 0 directly
   assign msize = ADDR_BITS'(csr_wdata);

   function automatic rsp_type mk(status_type st, addr_type a, addr_type b);
      rsp_type r;
      r.status        = st;
      r.region_start  = LEN_BITS'(a);
      r.region_length = LEN_BITS'(b);
      return r;
   endfunction

   logic fin_reset;
   logic [ADDR_BITS-1:0] rst_size;
   assign rst_size = ADDR_BITS'(1024 & ((64'd1 << ADDR_BITS) - 1));

   always_comb begin
      state_in = state_ff; policy_in = policy_ff;
      fcnt_in = fcnt_ff; ucnt_in = ucnt_ff; i_in = i_ff; pos_in = pos_ff;
      n1_in = n1_ff; n2_in = n2_ff; h1_in = h1_ff; h2_in = h2_ff;
      rm2_in = rm2_ff; rm2v_in = rm2v_ff; k_in = k_ff;
      cmd_in = cmd_ff; job_in = job_ff; len_in = len_ff;
      s_in = s_ff; l_in = l_ff; ms_in = ms_ff; ml_in = ml_ff;
      fins_in = fins_ff; mv_in = mv_ff;
      rsp_v_in = rsp_v_ff; rsp_in = rsp_ff;
      f_ra = '0; f_wa = '0; f_we = 1'b0; f_ws = '0; f_wl = '0;
      u_ra = '0; u_wa = '0; u_we = 1'b0; u_ws = '0; u_wl = '0; u_wj = '0;
      fin_reset = 1'b0;

      if (rsp_v_ff && rsp.ready) rsp_v_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (csr_we) begin
               if (csr_index == CSR_FIT_POLICY) begin
                  policy_in = csr_wdata[0];
               end else begin
                  f_we = 1'b1;
                  f_wl = AB'(msize);
                  ucnt_in = '0;
                  fcnt_in = (msize != '0) ? CW'(1) : '0;
               end
            end else if (req.valid && req.ready) begin
               cmd_in = req.payload.cmd;
               job_in = req.payload.job_id;
               // a length beyond the address range never fits: treat as zero
               len_in = ((32'(req.payload.req_length) >> ADDR_BITS) != 32'd0) ? '0
                        : AB'(req.payload.req_length);
               i_in = '0;
               state_in = S_UJOB_RD;
            end
         end
         // find job in used table
         S_UJOB_RD: begin
            if (i_ff >= ucnt_ff) begin
               // not present
               if (cmd_ff == CMD_RELEASE) begin
                  rsp_in = mk(ST_NOT_FND, '0, '0);
                  state_in = S_DONE;
               end else begin
                  i_in = '0;
                  state_in = S_FSRCH_RD;
               end
            end else begin
               u_ra = UA'(i_ff);
               state_in = S_UJOB_CHK;
            end
         end
         S_UJOB_CHK: begin
            if (u_rj == job_ff) begin
               if (cmd_ff == CMD_ALLOC) begin
                  rsp_in = mk(ST_PRESENT, '0, '0);
                  state_in = S_DONE;
               end else begin
                  k_in = i_ff;
                  s_in = u_rs; l_in = u_rl;
                  h1_in = 1'b0; h2_in = 1'b0;
                  i_in = '0;
                  state_in = S_FSRCH_RD;
               end
            end else begin
               i_in = i_ff + 1'b1;
               state_in = S_UJOB_RD;
            end
         end
         // free table scan: fit search (alloc) or neighbors (release)
         S_FSRCH_RD: begin
            if (i_ff >= fcnt_ff) begin
               if (cmd_ff == CMD_ALLOC) begin
                  rsp_in = mk(ST_NO_FIT, '0, '0);
                  state_in = S_DONE;
               end else begin
                  state_in = S_REL_CHK;
               end
            end else begin
               f_ra = FA'(i_ff);
               state_in = S_FSRCH_CHK;
            end
         end
         S_FSRCH_CHK: begin
            state_in = S_FSRCH_RD;
            i_in = i_ff + 1'b1;
            if (cmd_ff == CMD_ALLOC) begin
               if (len_ff != '0 && f_rl >= len_ff) begin
                  if (ucnt_ff >= CW'(MAX_JOBS)) begin
                     rsp_in = mk(ST_FULL, '0, '0);
                     state_in = S_DONE;
                  end else begin
                     s_in = f_rs; l_in = f_rl;
                     rm2_in = i_ff; rm2v_in = 1'b1;
                     fins_in = (f_rl > len_ff);
                     ms_in = f_rs + len_ff; ml_in = f_rl - len_ff;
                     rsp_in = mk(ST_OK, f_rs, len_ff);
                     // remove free[i], then insert used, then maybe free
                     pos_in = i_ff; rm2v_in = 1'b0;
                     i_in = i_ff;
                     state_in = S_FREM_RD;
                  end
               end
            end else begin
               if (f_rs + f_rl == s_ff) begin
                  n1_in = i_ff; h1_in = 1'b1;
               end
               if (s_ff + l_ff == f_rs) begin
                  n2_in = i_ff; h2_in = 1'b1;
               end
            end
         end
         S_REL_CHK: begin
            if (!h1_ff && !h2_ff && fcnt_ff >= CW'(FDEPTH)) begin
               rsp_in = mk(ST_FULL, '0, '0);
               state_in = S_DONE;
            end else begin
               rsp_in = mk(ST_OK, s_ff, l_ff);
               ms_in = s_ff; ml_in = l_ff;
               fins_in = 1'b1;
               // only neighbor indices were recorded during scan; entries are read below
               i_in = k_ff;
               state_in = S_UREM_RD;
            end
         end
         // used removal at k
         S_UREM_RD: begin
            if (i_ff + 1'b1 >= ucnt_ff) begin
               ucnt_in = ucnt_ff - 1'b1;
               // gather neighbor entries: read n1 first if present, else n2
               if (h1_ff) begin
                  f_ra = FA'(n1_ff);
                  i_in = '0;
               end else if (h2_ff) begin
                  f_ra = FA'(n2_ff);
                  i_in = CW'(1);
               end
               state_in = (h1_ff || h2_ff) ? S_FINS_CHK : S_FINS_RD;
               mv_in = 1'b1; // flag: neighbor gather mode
               i_in = h1_ff ? '0 : CW'(1);
               if (!(h1_ff || h2_ff)) begin
                  mv_in = 1'b0;
                  i_in = '0;
               end
            end else begin
               u_ra = UA'(i_ff + 1'b1);
               state_in = S_UREM_WR;
            end
         end
         S_UREM_WR: begin
            u_we = 1'b1; u_wa = UA'(i_ff);
            u_ws = u_rs; u_wl = u_rl; u_wj = u_rj;
            i_in = i_ff + 1'b1;
            state_in = S_UREM_RD;
         end
         // S_FINS_CHK doubles as neighbor gather when mv_ff is set
         S_FINS_CHK: begin
            if (mv_ff) begin
               if (i_ff == '0) begin
                  ms_in = f_rs; ml_in = ml_ff + f_rl;
                  if (h2_ff) begin
                     f_ra = FA'(n2_ff);
                     i_in = CW'(1);
                  end else begin
                     mv_in = 1'b0;
                     state_in = S_FREM_RD;
                     pos_in = n1_ff; rm2_in = n1_ff; rm2v_in = 1'b0;
                  end
               end else begin
                  ml_in = ml_ff + f_rl;
                  mv_in = 1'b0;
                  state_in = S_FREM_RD;
                  // remove higher index first
                  if (h1_ff && n1_ff > n2_ff) begin
                     pos_in = n1_ff; rm2_in = n2_ff; rm2v_in = 1'b1;
                  end else begin
                     pos_in = n2_ff; rm2_in = n1_ff; rm2v_in = h1_ff;
                  end
               end
               if (state_in == S_FREM_RD) i_in = pos_in;
            end else begin
               // insertion position search
               if (policy_ff ? (ml_ff < f_rl) : (ms_ff < f_rs)) begin
                  pos_in = i_ff;
                  i_in = fcnt_ff;
                  state_in = S_FSHIFT_RD;
               end else begin
                  i_in = i_ff + 1'b1;
                  state_in = S_FINS_RD;
               end
            end
         end
         // free removal at pos (i runs from pos)
         S_FREM_RD: begin
            if (i_ff + 1'b1 >= fcnt_ff) begin
               fcnt_in = fcnt_ff - 1'b1;
               if (rm2v_ff) begin
                  rm2v_in = 1'b0;
                  i_in = rm2_ff; pos_in = rm2_ff;
               end else if (cmd_ff == CMD_ALLOC) begin
                  i_in = '0;
                  state_in = S_UINS_RD;
               end else begin
                  i_in = '0;
                  state_in = S_FINS_RD;
               end
            end else begin
               f_ra = FA'(i_ff + 1'b1);
               state_in = S_FREM_WR;
            end
         end
         S_FREM_WR: begin
            f_we = 1'b1; f_wa = FA'(i_ff); f_ws = f_rs; f_wl = f_rl;
            i_in = i_ff + 1'b1;
            state_in = S_FREM_RD;
         end
         // used insertion, ordered by start
         S_UINS_RD: begin
            if (i_ff >= ucnt_ff) begin
               state_in = S_UINS_PUT;
               pos_in = ucnt_ff;
            end else begin
               u_ra = UA'(i_ff);
               state_in = S_UINS_CHK;
            end
         end
         S_UINS_CHK: begin
            if (s_ff < u_rs) begin
               pos_in = i_ff;
               i_in = ucnt_ff;
               state_in = S_USHIFT_RD;
            end else begin
               i_in = i_ff + 1'b1;
               state_in = S_UINS_RD;
            end
         end
         S_USHIFT_RD: begin
            if (i_ff <= pos_ff) begin
               state_in = S_UINS_PUT;
            end else begin
               u_ra = UA'(i_ff - 1'b1);
               state_in = S_USHIFT_WR;
            end
         end
         S_USHIFT_WR: begin
            u_we = 1'b1; u_wa = UA'(i_ff);
            u_ws = u_rs; u_wl = u_rl; u_wj = u_rj;
            i_in = i_ff - 1'b1;
            state_in = S_USHIFT_RD;
         end
         S_UINS_PUT: begin
            u_we = 1'b1; u_wa = UA'(pos_ff);
            u_ws = s_ff; u_wl = len_ff; u_wj = job_ff;
            ucnt_in = ucnt_ff + 1'b1;
            i_in = '0;
            state_in = fins_ff ? S_FINS_RD : S_DONE;
         end
         // free insertion of (ms, ml)
         S_FINS_RD: begin
            if (fcnt_ff >= CW'(FDEPTH)) begin
               state_in = S_DONE;
            end else if (i_ff >= fcnt_ff) begin
               pos_in = fcnt_ff;
               state_in = S_FINS_PUT;
            end else begin
               f_ra = FA'(i_ff);
               state_in = S_FINS_CHK;
            end
         end
         S_FSHIFT_RD: begin
            if (i_ff <= pos_ff) begin
               state_in = S_FINS_PUT;
            end else begin
               f_ra = FA'(i_ff - 1'b1);
               state_in = S_FSHIFT_WR;
            end
         end
         S_FSHIFT_WR: begin
            f_we = 1'b1; f_wa = FA'(i_ff); f_ws = f_rs; f_wl = f_rl;
            i_in = i_ff - 1'b1;
            state_in = S_FSHIFT_RD;
         end
         S_FINS_PUT: begin
            f_we = 1'b1; f_wa = FA'(pos_ff); f_ws = ms_ff; f_wl = ml_ff;
            fcnt_in = fcnt_ff + 1'b1;
            fins_in = 1'b0;
            state_in = S_DONE;
         end
         S_DONE: begin
            rsp_v_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      if (reset) begin
         fin_reset = 1'b1;
         f_we = 1'b1; f_wa = '0; f_ws = '0; f_wl = AB'(rst_size);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         policy_ff <= 1'b0;
         fcnt_ff <= (rst_size != '0) ? CW'(1) : '0;
         ucnt_ff <= '0;
         rsp_v_ff <= 1'b0;
         fins_ff <= 1'b0;
         mv_ff <= 1'b0;
         rm2v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         policy_ff <= policy_in;
         fcnt_ff <= fcnt_in;
         ucnt_ff <= ucnt_in;
         rsp_v_ff <= rsp_v_in;
         fins_ff <= fins_in;
         mv_ff <= mv_in;
         rm2v_ff <= rm2v_in;
      end
      i_ff <= i_in; pos_ff <= pos_in; n1_ff <= n1_in; n2_ff <= n2_in;
      h1_ff <= h1_in; h2_ff <= h2_in; rm2_ff <= rm2_in; k_ff <= k_in;
      cmd_ff <= cmd_in; job_ff <= job_in; len_ff <= len_in;
      s_ff <= s_in; l_ff <= l_in; ms_ff <= ms_in; ml_ff <= ml_in;
      rsp_ff <= fin_reset ? rsp_type'('0) : rsp_in;
   end
endmodule
